[rtl/core/mh2_pkg.sv]
// Shared constants, command types and helpers for the MurmurHash2 engine.
`default_nettype none

package mh2_pkg;

    // Mixing constants of the 32-bit scheme
    localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
    localparam int unsigned MIX_SHIFT   = 24;
    localparam int unsigned FIN_SHIFT_A = 13;
    localparam int unsigned FIN_SHIFT_B = 15;
    localparam logic [31:0] SEED_RESET  = 32'd5381;

    // Field widths
    localparam int unsigned LEN_W   = 31;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned COUNT_W = 3;

    // Datapath operation issued by the controller each cycle
    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_K1   = 3'd1,   // k = word * M
        OP_K2   = 3'd2,   // k = (k ^ k >> 24) * M
        OP_H    = 3'd3,   // h = (h * M) ^ k
        OP_TAIL = 3'd4,   // h = h * M
        OP_F1   = 3'd5,   // h = (h ^ h >> 13) * M
        OP_F2   = 3'd6    // h = h ^ h >> 15, publish result
    } op_t;

    typedef struct packed {
        logic load;       // capture the accepted request
        logic fold_tail;  // xor the tail bytes into the hash on load
        op_t  op;
    } dp_cmd_t;

    typedef struct packed {
        logic out_busy;   // result register full and not taken this cycle
    } dp_status_t;

    // Byte mask for one to three tail bytes; zero otherwise
    function automatic logic [WORD_W-1:0] tail_mask(input logic [COUNT_W-1:0] cnt);
        logic [WORD_W-1:0] mask;
        begin
            case (cnt)
                3'd1:    mask = 32'h0000_00ff;
                3'd2:    mask = 32'h0000_ffff;
                3'd3:    mask = 32'h00ff_ffff;
                default: mask = '0;
            endcase
            return mask;
        end
    endfunction

endpackage

`default_nettype wire

[rtl/core/murmur2_hash_engine.sv]
// Top level of the streaming 32-bit MurmurHash2 engine.
// A key streams in as little-endian 32-bit words, one request per word; the first
// request (tuser high) loads the hash with the seed xor key length, and the last
// (tlast high) folds in the byte count's tail and emits one finished hash. All
// multiplies go through a single shared 32x32 multiplier, which sets the rate: a
// non-last word is accepted, then takes three multiply steps; a full last word
// adds F1 and F2, a last word with one to three bytes takes TAIL, F1 and F2, and
// one with no bytes F1 and F2. A finished hash waits in an output register while
// the next key is accepted; the final step holds only if the previous result is
// still untaken. The seed register resets to 5381 and is written through the cfg
// channel, which is always ready; write it only while idle.
`default_nettype none

module murmur2_hash_engine
    import mh2_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write: seed
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,
    // Key words in
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,  // key_length[30:0], data_word[62:31],
                                            // byte_count[65:63], zero[71:66]
    input  wire logic [0:0]  s_axis_tuser,  // first_item[0]
    input  wire logic        s_axis_tlast,
    // Hash out
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata   // hash_value[31:0]
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic [LEN_W-1:0]   in_length;
    logic [WORD_W-1:0]  in_word;
    logic [COUNT_W-1:0] in_count;

    assign cfg_ready = 1'b1;

    // Unpack the request payload
    assign in_length = s_axis_tdata[LEN_W-1:0];
    assign in_word   = s_axis_tdata[LEN_W+WORD_W-1:LEN_W];
    assign in_count  = s_axis_tdata[LEN_W+WORD_W+COUNT_W-1:LEN_W+WORD_W];

    mh2_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .in_count (in_count),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mh2_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .in_first  (s_axis_tuser[0]),
        .in_length (in_length),
        .in_word   (in_word),
        .in_count  (in_count),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

    // Never overwrite a result that is still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_F2) |-> !status.out_busy)
        else $error("final step issued while result register busy");

    // Capture only on an accepted request
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> (s_axis_tvalid && s_axis_tready))
        else $error("load without accepted request");

    // A new result comes only from the final step
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(cmd.op == OP_F2))
        else $error("result appeared without final step");

    // Word mixing runs its two key multiplies back to back
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_K1) |=> (cmd.op == OP_K2))
        else $error("key mix sequence broken");

endmodule

`default_nettype wire

[rtl/core/mh2_ctrl.sv]
// Controller state machine that sequences the shared multiplier per request.
`default_nettype none

module mh2_ctrl
    import mh2_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    input  wire logic               in_last,
    input  wire logic [COUNT_W-1:0] in_count,
    output logic                    in_ready,
    input  dp_status_t              status,
    output dp_cmd_t                 cmd
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_K1   = 7'b0000010,
        ST_K2   = 7'b0000100,
        ST_H    = 7'b0001000,
        ST_TAIL = 7'b0010000,
        ST_F1   = 7'b0100000,
        ST_F2   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   last_reg, last_next;
    logic   accept;
    logic   whole_word;
    logic   has_tail;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // Classify the request: whole word, short tail, or no data bytes
    assign whole_word = !in_last || in_count[COUNT_W-1];
    assign has_tail   = in_last && !in_count[COUNT_W-1] && (in_count != '0);

    // Next state and command
    always_comb begin
        state_next    = state_reg;
        last_next     = last_reg;
        cmd.load      = 1'b0;
        cmd.fold_tail = 1'b0;
        cmd.op        = OP_NONE;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load      = 1'b1;
                    cmd.fold_tail = has_tail;
                    last_next     = in_last;
                    if (whole_word) begin
                        state_next = ST_K1;
                    end else if (has_tail) begin
                        state_next = ST_TAIL;
                    end else begin
                        state_next = ST_F1;
                    end
                end
            end
            ST_K1: begin
                cmd.op     = OP_K1;
                state_next = ST_K2;
            end
            ST_K2: begin
                cmd.op     = OP_K2;
                state_next = ST_H;
            end
            ST_H: begin
                cmd.op     = OP_H;
                state_next = last_reg ? ST_F1 : ST_IDLE;
            end
            ST_TAIL: begin
                cmd.op     = OP_TAIL;
                state_next = ST_F1;
            end
            ST_F1: begin
                cmd.op     = OP_F1;
                state_next = ST_F2;
            end
            ST_F2: begin
                // hold until the result register can take the hash
                if (!status.out_busy) begin
                    cmd.op     = OP_F2;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/mh2_datapath.sv]
// Hash datapath: seed register, running hash, shared multiplier, result register.
`default_nettype none

module mh2_datapath
    import mh2_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_write,
    input  wire logic [WORD_W-1:0]  cfg_data,
    input  wire logic               in_first,
    input  wire logic [LEN_W-1:0]   in_length,
    input  wire logic [WORD_W-1:0]  in_word,
    input  wire logic [COUNT_W-1:0] in_count,
    input  dp_cmd_t                 cmd,
    output dp_status_t              status,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [WORD_W-1:0]       out_data
);

    logic [WORD_W-1:0] seed_reg;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [WORD_W-1:0] k_reg, k_next;
    logic [WORD_W-1:0] h_reg, h_next;
    logic [WORD_W-1:0] out_data_reg, out_data_next;
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] mul_a;
    logic [WORD_W-1:0] product;
    logic [WORD_W-1:0] h_base;
    logic [WORD_W-1:0] h_final;

    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;

    // Select the multiplier operand
    always_comb begin
        case (cmd.op)
            OP_K1:   mul_a = word_reg;
            OP_K2:   mul_a = k_reg ^ (k_reg >> MIX_SHIFT);
            OP_H:    mul_a = h_reg;
            OP_TAIL: mul_a = h_reg;
            OP_F1:   mul_a = h_reg ^ (h_reg >> FIN_SHIFT_A);
            default: mul_a = '0;
        endcase
    end

    // Shared 32x32 multiplier, low half kept
    assign product = WORD_W'(mul_a * MIX_MUL);

    assign h_base  = in_first ? (seed_reg ^ {1'b0, in_length}) : h_reg;
    assign h_final = h_reg ^ (h_reg >> FIN_SHIFT_B);

    // Advance the hash registers
    always_comb begin
        word_next      = word_reg;
        k_next         = k_reg;
        h_next         = h_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.load) begin
            word_next = in_word;
            h_next    = cmd.fold_tail ? (h_base ^ (in_word & tail_mask(in_count))) : h_base;
        end
        case (cmd.op)
            OP_K1:   k_next = product;
            OP_K2:   k_next = product;
            OP_H:    h_next = product ^ k_reg;
            OP_TAIL: h_next = product;
            OP_F1:   h_next = product;
            OP_F2: begin
                h_next         = h_final;
                out_data_next  = h_final;
                out_valid_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg      <= SEED_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_write) begin
                seed_reg <= cfg_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge aclk) begin
        word_reg     <= word_next;
        k_reg        <= k_next;
        h_reg        <= h_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire
